>>> rtl/core/rgbpte_pkg.sv
// Shared types and constants for the RGB LED pulse timing encoder.
// No dependencies.
package rgbpte_pkg;

    localparam int COLOR_W = 8;
    localparam int BRIGHT_W = 9;
    localparam int TICK_W = 16;
    localparam int CMP_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam logic [BRIGHT_W-1:0] FULL_SCALE = 9'd256;

    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_VALUE = 2'd2;

    localparam logic [TICK_W-1:0] HIGH_TICKS_RST = 16'd64;
    localparam logic [TICK_W-1:0] LOW_TICKS_RST = 16'd32;
    localparam logic [CMP_W-1:0] STOP_VALUE_RST = 32'd65535;

    typedef struct packed {
        logic [COLOR_W-1:0]  red;
        logic [COLOR_W-1:0]  green;
        logic [COLOR_W-1:0]  blue;
        logic [BRIGHT_W-1:0] brightness;
    } t_in_item;

    typedef struct packed {
        logic [CMP_W-1:0] compare_value;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic [TICK_W-1:0] high_ticks;
        logic [TICK_W-1:0] low_ticks;
        logic [CMP_W-1:0]  stop_value;
    } t_cfg;

endpackage

>>> rtl/core/rgb_led_pulse_timing_encoder_top.sv
// Path: front register, two-entry queue (lets the front run ahead), back stage,
// output register. Throughput: one compare value per cycle unless the output
// stalls, set by the bit walk; an item gives 1 + 6*BITS_PER_COLOR (49) values.
// Reset: synchronous active low, clears control and restores register defaults.
// Holds the configuration registers and ties front, queue and back together.
// Depends on rgbpte_pkg, rgbpte_front, rgbpte_queue, rgbpte_back.
module rgb_led_pulse_timing_encoder_top #(
    parameter int BITS_PER_COLOR = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  rgbpte_pkg::t_in_item                  i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output rgbpte_pkg::t_out_item                 o_out_data,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [rgbpte_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rgbpte_pkg::CMP_W-1:0]          i_cfg_data
);
    import rgbpte_pkg::*;

    localparam int NBITS = 3 * BITS_PER_COLOR;

    t_cfg             r_cfg;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_empty;
    logic [NBITS-1:0] push_bits;
    logic [NBITS-1:0] pop_bits;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_ticks <= HIGH_TICKS_RST;
            r_cfg.low_ticks  <= LOW_TICKS_RST;
            r_cfg.stop_value <= STOP_VALUE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HIGH_TICKS: r_cfg.high_ticks <= i_cfg_data[TICK_W-1:0];
                CFG_LOW_TICKS:  r_cfg.low_ticks  <= i_cfg_data[TICK_W-1:0];
                CFG_STOP_VALUE: r_cfg.stop_value <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rgbpte_front #(.BITS_PER_COLOR(BITS_PER_COLOR)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_push      (push),
        .o_push_bits (push_bits),
        .i_q_full    (q_full)
    );

    rgbpte_queue #(.WIDTH(NBITS)) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_bits),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_empty     (q_empty),
        .o_pop_data  (pop_bits)
    );

    rgbpte_back #(.BITS_PER_COLOR(BITS_PER_COLOR)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (q_empty),
        .i_q_bits    (pop_bits),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> rtl/core/rgbpte_front.sv
// Front stage: takes color items, scales channels by brightness and packs
// the bit stream (red, green, blue, MSB first). Depends on rgbpte_pkg.
module rgbpte_front #(
    parameter int BITS_PER_COLOR = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  rgbpte_pkg::t_in_item      i_in_data,
    output logic                      o_push,
    output logic [3*BITS_PER_COLOR-1:0] o_push_bits,
    input  logic                      i_q_full
);
    import rgbpte_pkg::*;

    localparam int NBITS = 3 * BITS_PER_COLOR;

    logic                 r_valid;
    logic [NBITS-1:0]     r_bits;
    logic [NBITS-1:0]     n_bits;
    logic [BRIGHT_W-1:0]  bright;
    logic [COLOR_W-1:0]   ch [3];
    logic [COLOR_W-1:0]   raw [3];
    logic [16:0]          prod [3];
    logic                 take;

    assign o_push      = r_valid && !i_q_full;
    assign take        = !r_valid || o_push;
    assign o_in_stall  = !take;
    assign o_push_bits = r_bits;

    always_comb begin
        bright = (i_in_data.brightness > FULL_SCALE) ? FULL_SCALE : i_in_data.brightness;
        raw[0] = i_in_data.red;
        raw[1] = i_in_data.green;
        raw[2] = i_in_data.blue;
        n_bits = '0;
        for (int c = 0; c < 3; c++) begin
            prod[c] = {9'd0, raw[c]} * {8'd0, bright};
            ch[c]   = prod[c][15:8];
            for (int i = 0; i < BITS_PER_COLOR; i++) begin
                if (i < COLOR_W) begin
                    n_bits[NBITS-1-(c*BITS_PER_COLOR+(BITS_PER_COLOR-1-i))] = ch[c][i%COLOR_W];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= i_in_valid;
        end
        if (take && i_in_valid) begin
            r_bits <= n_bits;
        end
    end

endmodule

>>> rtl/core/rgbpte_queue.sv
// Two-entry queue between the front and back stages.
// Depends on nothing beyond its width parameter.
module rgbpte_queue #(
    parameter int WIDTH = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_pop_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    assign o_full     = (r_count == 2'd2);
    assign o_empty    = (r_count == 2'd0);
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

>>> rtl/core/rgbpte_back.sv
// Back stage: walks the packed bit stream and emits the running toggle
// compare values through an output register. Depends on rgbpte_pkg.
module rgbpte_back #(
    parameter int BITS_PER_COLOR = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rgbpte_pkg::t_cfg            i_cfg,
    input  logic                        i_q_empty,
    input  logic [3*BITS_PER_COLOR-1:0] i_q_bits,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output rgbpte_pkg::t_out_item       o_out_data
);
    import rgbpte_pkg::*;

    localparam int NBITS = 3 * BITS_PER_COLOR;
    localparam int RUN_LEN = 1 + 2 * NBITS;
    localparam int CNT_W = $clog2(RUN_LEN);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RUN_LEN - 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [CMP_W-1:0] r_sum;
    logic [NBITS-1:0] r_bits;
    logic             r_half;
    logic             r_out_valid;
    t_out_item        r_out_data;

    logic             out_free;
    logic             emit;
    logic             is_last;
    logic             bit_one;
    logic [TICK_W-1:0] step;
    logic [CMP_W-1:0] n_sum;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign emit        = r_busy && out_free;
    assign is_last     = (r_cnt == CNT_LAST);
    assign o_pop       = !i_q_empty && (!r_busy || (emit && is_last));
    assign bit_one     = r_bits[NBITS-1];
    assign step        = (bit_one ^ r_half) ? i_cfg.high_ticks : i_cfg.low_ticks;
    assign n_sum       = r_sum + {{(CMP_W-TICK_W){1'b0}}, step};
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (emit && is_last) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end

        if (o_pop) begin
            r_cnt  <= '0;
            r_sum  <= '0;
            r_half <= 1'b0;
            r_bits <= i_q_bits;
        end else if (emit) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt != '0) begin
                r_sum  <= n_sum;
                r_half <= !r_half;
                if (r_half) begin
                    r_bits <= {r_bits[NBITS-2:0], 1'b0};
                end
            end
        end

        if (emit) begin
            if (is_last) begin
                r_out_data.compare_value <= i_cfg.stop_value;
                r_out_data.last          <= 1'b1;
            end else if (r_cnt == '0) begin
                r_out_data.compare_value <= '0;
                r_out_data.last          <= 1'b0;
            end else begin
                r_out_data.compare_value <= n_sum;
                r_out_data.last          <= 1'b0;
            end
        end
    end

endmodule

>>> bench/testbench.sv
// Self-checking bench for rgb_led_pulse_timing_encoder_top: drives colors and timing
// registers, predicts every toggle compare value and checks each output transfer.
// Depends on rgbpte_pkg and the encoder RTL.
module testbench;
    import rgbpte_pkg::*;

    localparam int BPC = 8;
    localparam int RUN_LEN = 1 + 6 * BPC;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_CAP = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CMP_W-1:0]     i_cfg_data;

    t_out_item        toggle_q[$];
    t_out_item        want;
    logic [TICK_W-1:0] cur_high;
    logic [TICK_W-1:0] cur_low;
    logic [CMP_W-1:0] cur_stop;
    int               send_idle_pct = 0;
    int               stall_pct = 0;
    int               errors = 0;
    int               colors_sent = 0;
    int               values_seen = 0;
    int               reg_writes = 0;
    int               cycle_count = 0;

    rgb_led_pulse_timing_encoder_top #(
        .BITS_PER_COLOR(BPC)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d values outstanding", cycle_count,
                toggle_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [CMP_W-1:0] got,
                                   input logic [CMP_W-1:0] exp_val);
        if (errors < PRINT_CAP) begin
            $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got,
                exp_val);
        end
        errors++;
    endtask

    // Expected toggle run for one color under the current timing registers.
    function automatic void encode_color(input t_in_item c);
        logic [BRIGHT_W-1:0] level;
        logic [COLOR_W-1:0]  raw [3];
        logic [16:0]         prod;
        logic [COLOR_W-1:0]  scaled;
        logic [CMP_W-1:0]    sum;
        logic                one;
        t_out_item           r;
        int                  n;
        level = (c.brightness > FULL_SCALE) ? FULL_SCALE : c.brightness;
        raw[0] = c.red;
        raw[1] = c.green;
        raw[2] = c.blue;
        sum = '0;
        r.compare_value = '0;
        r.last = 1'b0;
        toggle_q = {toggle_q, r};
        n = 1;
        for (int k = 0; k < 3; k++) begin
            prod = {9'd0, raw[k]} * {8'd0, level};
            scaled = prod[15:8];
            for (int b = BPC - 1; b >= 0; b--) begin
                one = (b < COLOR_W) ? scaled[b] : 1'b0;
                for (int h = 0; h < 2; h++) begin
                    sum = sum + CMP_W'((one ^ h[0]) ? cur_high : cur_low);
                    r.last = (n == RUN_LEN - 1);
                    r.compare_value = r.last ? cur_stop : sum;
                    toggle_q = {toggle_q, r};
                    n++;
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_high = HIGH_TICKS_RST;
            cur_low = LOW_TICKS_RST;
            cur_stop = STOP_VALUE_RST;
            toggle_q.delete();
        end else begin
            if (o_out_valid && !i_out_stall) begin
                values_seen++;
                if (toggle_q.size() == 0) begin
                    report_mismatch("unexpected compare value", o_out_data.compare_value, '0);
                end else begin
                    want = toggle_q.pop_front();
                    if (o_out_data.compare_value !== want.compare_value)
                        report_mismatch("compare_value", o_out_data.compare_value,
                            want.compare_value);
                    if (o_out_data.last !== want.last)
                        report_mismatch("last", CMP_W'(o_out_data.last), CMP_W'(want.last));
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                reg_writes++;
                case (i_cfg_index)
                    CFG_HIGH_TICKS: cur_high = i_cfg_data[TICK_W-1:0];
                    CFG_LOW_TICKS:  cur_low = i_cfg_data[TICK_W-1:0];
                    CFG_STOP_VALUE: cur_stop = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                colors_sent++;
                encode_color(i_in_data);
            end
        end
    end

    // Valid stays high across back-to-back transfers; it drops only for a gap.
    task automatic send_color(input t_in_item c);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= c;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_rgb(input int r, input int g, input int b, input int br);
        t_in_item c;
        c.red = COLOR_W'(r);
        c.green = COLOR_W'(g);
        c.blue = COLOR_W'(b);
        c.brightness = BRIGHT_W'(br);
        send_color(c);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (toggle_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CMP_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Upper bits of tick writes are random: only the low 16 bits should land.
    task automatic program_timing(input logic [TICK_W-1:0] high_t, input logic [TICK_W-1:0] low_t,
                                  input logic [CMP_W-1:0] stop_v);
        wait_idle();
        write_reg(CFG_HIGH_TICKS, {16'($urandom), high_t});
        write_reg(CFG_LOW_TICKS, {16'($urandom), low_t});
        write_reg(CFG_STOP_VALUE, stop_v);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_default_timing();
        send_rgb(0, 0, 0, 0);
        send_rgb(255, 255, 255, 256);
        send_rgb(255, 255, 255, 511);
        send_rgb(255, 128, 1, 257);
        send_rgb(255, 255, 255, 255);
        send_rgb(8'hAA, 8'h55, 8'hF0, 256);
        send_rgb(200, 100, 50, 1);
        send_rgb(255, 0, 255, 128);
    endtask

    task automatic test_register_extremes();
        program_timing(16'd1, 16'd1, 32'd0);
        send_rgb(8'h0F, 8'hF0, 8'h81, 300);
        send_rgb(255, 255, 255, 256);
        program_timing(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_rgb(255, 255, 255, 256);
        send_rgb(0, 0, 0, 256);
        program_timing(16'd0, 16'd0, 32'h1234_5678);
        send_rgb(8'hA5, 8'h5A, 8'hFF, 256);
        program_timing(16'd0, 16'd17, 32'hDEAD_BEEF);
        send_rgb(8'h3C, 8'hC3, 8'h99, 511);
        program_timing(16'hFFFF, 16'd1, 32'h8000_0000);
        send_rgb(8'h80, 8'h01, 8'h7F, 256);
        // index 3 maps to no register and must leave timing untouched
        wait_idle();
        write_reg(CFG_UNUSED, $urandom);
        i_cfg_valid <= 1'b0;
        send_rgb(8'h80, 8'h01, 8'h7F, 256);
        send_rgb(100, 150, 250, 192);
    endtask

    task automatic test_random_traffic();
        int send_mix [4] = '{0, 48, 0, 22};
        int stall_mix [4] = '{0, 0, 48, 22};
        int br;
        for (int p = 0; p < 4; p++) begin
            program_timing(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                $urandom);
            send_idle_pct = send_mix[p];
            stall_pct = stall_mix[p];
            for (int i = 0; i < 80; i++) begin
                case ($urandom_range(9))
                    6, 7:    br = $urandom_range(256, 511);
                    8:       br = $urandom_range(0, 16);
                    9:       br = $urandom_range(240, 272);
                    default: br = $urandom_range(0, 511);
                endcase
                if (i == 40) wait_idle();
                send_rgb($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                    br);
            end
        end
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_HIGH_TICKS;
        i_cfg_data <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_timing();
        test_register_extremes();
        test_random_traffic();
        wait_idle();
        repeat (10) @(posedge i_clk);
        $display("covered %0d colors, %0d compare values, %0d register writes", colors_sent,
            values_seen, reg_writes);
        $display("four sender/receiver idle mixes, tick and stop extremes, unused index");
        if (errors == 0 && toggle_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/rgbpte_pkg.sv
rtl/core/rgbpte_front.sv
rtl/core/rgbpte_queue.sv
rtl/core/rgbpte_back.sv
rtl/core/rgb_led_pulse_timing_encoder_top.sv
bench/testbench.sv
